// ----- hdl/pcrl_pkg.sv -----
// shared types and constants for the per-client window rate limiter
package pcrl_pkg;

    localparam int unsigned DEPTH  = 64;
    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned TOK_W  = 17;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned REG_W  = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic             RST_LIMIT_ENABLED = 1'b0;
    localparam logic [CNT_W-1:0] RST_REQUESTS      = 16'd100;
    localparam logic [CNT_W-1:0] RST_BURST         = 16'd0;
    localparam logic [CNT_W-1:0] RST_WINDOW        = 16'd60;

    typedef enum logic [REG_W-1:0] {
        REG_LIMIT_ENABLED = 2'd0,
        REG_REQUESTS      = 2'd1,
        REG_BURST         = 2'd2,
        REG_WINDOW        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [KEY_W-1:0]  client_key;
        logic [TIME_W-1:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic             allowed;
        logic [CNT_W-1:0] retry_secs;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] win_begin;
    } entry_t;

    typedef struct packed {
        logic             limit_enabled;
        logic [CNT_W-1:0] requests_per_window;
        logic [CNT_W-1:0] burst_allowance;
        logic [CNT_W-1:0] window_seconds;
    } cfg_t;

endpackage

// ----- hdl/per_client_window_rate_limiter_unit.sv -----
// per-client fixed-window rate limiter: config registers, bucket ring, sequencer
//
//  channel   direction  handshake           beat
//  in        sink       in_valid/in_stall   in_data (client_key, now_seconds)
//  out       source     out_valid/out_stall out_data (allowed, retry_secs)
//  cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
//  disabled or zero capacity: the verdict is set at the input beat and the result is
//  registered from the finish state; otherwise one turn of the bucket ring to look up
//  the key, then rotating on to the chosen bucket; one request in flight at a time
//  a new request is taken while a finished result still waits on out_stall
//  rst_n clears all bucket valid bits and the victim pointer at once, no sweep
module per_client_window_rate_limiter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pcrl_pkg::req_t                in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pcrl_pkg::rsp_t                out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcrl_pkg::REG_W-1:0]    cfg_index,
    input  logic [pcrl_pkg::CNT_W-1:0]    cfg_data
);

    pcrl_pkg::cfg_t   cfg_reg;
    pcrl_pkg::entry_t ring [pcrl_pkg::DEPTH];
    pcrl_pkg::entry_t tail;
    logic             shift;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_enabled       <= pcrl_pkg::RST_LIMIT_ENABLED;
            cfg_reg.requests_per_window <= pcrl_pkg::RST_REQUESTS;
            cfg_reg.burst_allowance     <= pcrl_pkg::RST_BURST;
            cfg_reg.window_seconds      <= pcrl_pkg::RST_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcrl_pkg::REG_LIMIT_ENABLED: cfg_reg.limit_enabled       <= cfg_data[0];
                pcrl_pkg::REG_REQUESTS:      cfg_reg.requests_per_window <= cfg_data;
                pcrl_pkg::REG_BURST:         cfg_reg.burst_allowance     <= cfg_data;
                pcrl_pkg::REG_WINDOW:        cfg_reg.window_seconds      <= cfg_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // ring of buckets: each cell loads from the next one, the last from the sequencer
    for (genvar g = 0; g < pcrl_pkg::DEPTH; g++)
    begin : g_cell
        if (g == pcrl_pkg::DEPTH - 1)
        begin : g_last
            pcrl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .ent_in  (tail),
                .ent_out (ring[g])
            );
        end
        else
        begin : g_mid
            pcrl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .ent_in  (ring[g+1]),
                .ent_out (ring[g])
            );
        end
    end

    pcrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .head      (ring[0]),
        .tail      (tail),
        .shift     (shift)
    );

endmodule

// ----- hdl/pcrl_cell.sv -----
// one bucket of the rotating table, passes its entry to the neighbor on shift
module pcrl_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  pcrl_pkg::entry_t ent_in,
    output pcrl_pkg::entry_t ent_out
);

    logic                           valid_reg;
    logic [pcrl_pkg::KEY_W-1:0]     key_reg;
    logic [pcrl_pkg::TOK_W-1:0]     tokens_reg;
    logic [pcrl_pkg::TIME_W-1:0]    start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= ent_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg    <= ent_in.key;
            tokens_reg <= ent_in.tokens;
            start_reg  <= ent_in.win_begin;
        end
    end

    assign ent_out = '{valid: valid_reg, key: key_reg, tokens: tokens_reg,
                       win_begin: start_reg};

endmodule

// ----- hdl/pcrl_ctrl.sv -----
// sequencer: walks the ring, picks the bucket, applies the window update
module pcrl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  pcrl_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  pcrl_pkg::req_t   in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output pcrl_pkg::rsp_t   out_data,
    input  pcrl_pkg::entry_t head,
    output pcrl_pkg::entry_t tail,
    output logic             shift
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PICK,
        S_SEEK,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t                       state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;
    pcrl_pkg::rsp_t               out_data_reg, out_data_next;
    logic [pcrl_pkg::IDX_W-1:0]   head_idx_reg, head_idx_next;
    logic [pcrl_pkg::IDX_W-1:0]   step_reg, step_next;
    logic [pcrl_pkg::IDX_W-1:0]   victim_reg, victim_next;
    logic                         hit_reg, hit_next;
    logic [pcrl_pkg::IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic                         free_reg, free_next;
    logic [pcrl_pkg::IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [pcrl_pkg::IDX_W-1:0]   target_reg, target_next;
    logic                         insert_reg, insert_next;

    pcrl_pkg::req_t               req_reg, req_next;
    logic [pcrl_pkg::TOK_W-1:0]   cap_reg, cap_next;
    pcrl_pkg::rsp_t               pend_reg, pend_next;

    logic                         accept;
    logic [pcrl_pkg::TOK_W-1:0]   cap_in;
    logic [pcrl_pkg::IDX_W-1:0]   head_idx_inc;
    logic [pcrl_pkg::IDX_W-1:0]   victim_inc;
    logic                         key_hit;

    pcrl_pkg::entry_t             cur;
    logic [pcrl_pkg::TIME_W-1:0]  elapsed;
    logic                         expired;
    logic [pcrl_pkg::TOK_W-1:0]   tok_now;
    logic [pcrl_pkg::TIME_W-1:0]  start_now;
    logic [pcrl_pkg::CNT_W-1:0]   elapsed_now;
    pcrl_pkg::entry_t             updated;
    pcrl_pkg::rsp_t               verdict;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cap_in = {1'b0, cfg.requests_per_window} + {1'b0, cfg.burst_allowance};

    assign head_idx_inc = (head_idx_reg == pcrl_pkg::LAST_IDX) ? '0 : head_idx_reg + 1'b1;
    assign victim_inc   = (victim_reg == pcrl_pkg::LAST_IDX) ? '0 : victim_reg + 1'b1;
    assign key_hit      = head.valid && (head.key == req_reg.client_key);

    // bucket update for the entry at the head, or a fresh one on insert
    always_comb
    begin
        if (insert_reg)
        begin
            cur = '{valid: 1'b1, key: req_reg.client_key, tokens: cap_reg,
                    win_begin: req_reg.now_seconds};
        end
        else
        begin
            cur = head;
        end
        elapsed = req_reg.now_seconds - cur.win_begin;
        expired = (elapsed >= {{(pcrl_pkg::TIME_W - pcrl_pkg::CNT_W){1'b0}},
                               cfg.window_seconds});
        tok_now     = expired ? cap_reg : cur.tokens;
        start_now   = expired ? req_reg.now_seconds : cur.win_begin;
        elapsed_now = expired ? '0 : elapsed[pcrl_pkg::CNT_W-1:0];
        updated     = cur;
        updated.win_begin = start_now;
        if (tok_now != '0)
        begin
            updated.tokens = tok_now - 1'b1;
            verdict = '{allowed: 1'b1, retry_secs: '0};
        end
        else
        begin
            updated.tokens = tok_now;
            verdict = '{allowed: 1'b0, retry_secs: cfg.window_seconds - elapsed_now};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        head_idx_next  = head_idx_reg;
        step_next      = step_reg;
        victim_next    = victim_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        target_next    = target_reg;
        insert_next    = insert_reg;
        req_next       = req_reg;
        cap_next       = cap_reg;
        pend_next      = pend_reg;
        shift          = 1'b0;
        tail           = head;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next  = in_data;
                    cap_next  = cap_in;
                    step_next = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    if (!cfg.limit_enabled)
                    begin
                        pend_next  = '{allowed: 1'b1, retry_secs: '0};
                        state_next = S_FINISH;
                    end
                    else if (cap_in == '0)
                    begin
                        pend_next  = '{allowed: 1'b0, retry_secs: cfg.window_seconds};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                // one full turn of the ring, looking at each bucket at the head
                shift         = 1'b1;
                head_idx_next = head_idx_inc;
                step_next     = step_reg + 1'b1;
                if (key_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = head_idx_reg;
                end
                if (!head.valid && (!free_reg || (head_idx_reg < free_idx_reg)))
                begin
                    free_next     = 1'b1;
                    free_idx_next = head_idx_reg;
                end
                if (step_reg == pcrl_pkg::LAST_IDX)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                insert_next = !hit_reg;
                if (hit_reg)
                begin
                    target_next = hit_idx_reg;
                end
                else if (free_reg)
                begin
                    target_next = free_idx_reg;
                end
                else
                begin
                    target_next = victim_reg;
                    victim_next = victim_inc;
                end
                state_next = S_SEEK;
            end
            S_SEEK:
            begin
                if (head_idx_reg == target_reg)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    shift         = 1'b1;
                    head_idx_next = head_idx_inc;
                end
            end
            S_APPLY:
            begin
                // updated bucket goes in at the tail as the head moves on
                shift         = 1'b1;
                tail          = updated;
                head_idx_next = head_idx_inc;
                pend_next     = verdict;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            head_idx_reg  <= '0;
            step_reg      <= '0;
            victim_reg    <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            target_reg    <= '0;
            insert_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            head_idx_reg  <= head_idx_next;
            step_reg      <= step_next;
            victim_reg    <= victim_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            free_reg      <= free_next;
            free_idx_reg  <= free_idx_next;
            target_reg    <= target_next;
            insert_reg    <= insert_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        cap_reg  <= cap_next;
        pend_reg <= pend_next;
    end

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted beat did not start work");

    a_apply_at_target: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> head_idx_reg == target_reg)
        else $error("bucket update away from the chosen slot");

    a_insert_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> insert_reg == !hit_reg)
        else $error("insert decision disagrees with key search");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && !(out_valid_reg && out_stall)
        |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not loaded when output was free");

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_idx_reg <= pcrl_pkg::LAST_IDX && victim_reg <= pcrl_pkg::LAST_IDX)
        else $error("ring index out of range");
`endif

endmodule

// ----- verif/pcrl_limit_check.sv -----
// checker for the rate limiter: watches all channels, predicts each reply, compares
module pcrl_limit_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  pcrl_pkg::req_t                in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  pcrl_pkg::rsp_t                out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pcrl_pkg::REG_W-1:0]    cfg_index,
    input  logic [pcrl_pkg::CNT_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    pcrl_pkg::cfg_t              limits = '{pcrl_pkg::RST_LIMIT_ENABLED,
                                            pcrl_pkg::RST_REQUESTS,
                                            pcrl_pkg::RST_BURST,
                                            pcrl_pkg::RST_WINDOW};
    logic                        bucket_used   [pcrl_pkg::DEPTH];
    logic [pcrl_pkg::KEY_W-1:0]  bucket_key    [pcrl_pkg::DEPTH];
    logic [pcrl_pkg::TOK_W-1:0]  bucket_tokens [pcrl_pkg::DEPTH];
    logic [pcrl_pkg::TIME_W-1:0] bucket_start  [pcrl_pkg::DEPTH];
    logic [pcrl_pkg::IDX_W-1:0]  victim = '0;
    pcrl_pkg::rsp_t              pending_replies [$];
    int                          errors = 0;

    initial
    begin
        foreach (bucket_used[i])
        begin
            bucket_used[i] = 1'b0;
        end
    end

    // updates the bucket table for one request and returns the reply it earns
    function automatic pcrl_pkg::rsp_t grant_or_deny(input pcrl_pkg::req_t req);
        pcrl_pkg::rsp_t              reply;
        logic [pcrl_pkg::TOK_W-1:0]  capacity;
        logic [pcrl_pkg::TIME_W-1:0] elapsed;
        logic                        hit;
        int                          slot;
        int                          i;
        reply.allowed    = 1'b1;
        reply.retry_secs = '0;
        if (!limits.limit_enabled)
        begin
            return reply;
        end
        capacity = {1'b0, limits.requests_per_window} + {1'b0, limits.burst_allowance};
        if (capacity == '0)
        begin
            reply.allowed    = 1'b0;
            reply.retry_secs = limits.window_seconds;
            return reply;
        end
        hit  = 1'b0;
        slot = -1;
        for (i = 0; i < pcrl_pkg::DEPTH; i++)
        begin
            if (!hit && bucket_used[i] && bucket_key[i] == req.client_key)
            begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (!hit)
        begin
            for (i = 0; i < pcrl_pkg::DEPTH; i++)
            begin
                if (slot < 0 && !bucket_used[i])
                begin
                    slot = i;
                end
            end
            // table full: evict round-robin
            if (slot < 0)
            begin
                slot   = victim;
                victim = victim + 1'b1;
            end
            bucket_used[slot]   = 1'b1;
            bucket_key[slot]    = req.client_key;
            bucket_tokens[slot] = capacity;
            bucket_start[slot]  = req.now_seconds;
        end
        // modular difference, so time going backwards looks like a long gap
        elapsed = req.now_seconds - bucket_start[slot];
        if (elapsed >= {16'd0, limits.window_seconds})
        begin
            bucket_tokens[slot] = capacity;
            bucket_start[slot]  = req.now_seconds;
            elapsed             = '0;
        end
        if (bucket_tokens[slot] != '0)
        begin
            bucket_tokens[slot] = bucket_tokens[slot] - 1'b1;
            return reply;
        end
        reply.allowed    = 1'b0;
        reply.retry_secs = limits.window_seconds - elapsed[pcrl_pkg::CNT_W-1:0];
        return reply;
    endfunction

    always @(posedge clk)
    begin : watch
        pcrl_pkg::rsp_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    $error("result beat with no request outstanding: allowed %0d retry_secs %0d",
                           out_data.allowed, out_data.retry_secs);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (out_data.allowed !== want.allowed)
                    begin
                        errors++;
                        $error("allowed: expected %0d, got %0d", want.allowed, out_data.allowed);
                    end
                    if (out_data.retry_secs !== want.retry_secs)
                    begin
                        errors++;
                        $error("retry_secs: expected %0d, got %0d",
                               want.retry_secs, out_data.retry_secs);
                    end
                end
            end
            // a request taken at this edge still sees the old register values
            if (in_valid && !in_stall)
            begin
                pending_replies.push_back(grant_or_deny(in_data));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (pcrl_pkg::reg_idx_t'(cfg_index))
                    pcrl_pkg::REG_LIMIT_ENABLED: limits.limit_enabled       = cfg_data[0];
                    pcrl_pkg::REG_REQUESTS:      limits.requests_per_window = cfg_data;
                    pcrl_pkg::REG_BURST:         limits.burst_allowance     = cfg_data;
                    pcrl_pkg::REG_WINDOW:        limits.window_seconds      = cfg_data;
                    default: ;
                endcase
            end
        end
        mismatches  <= errors;
        outstanding <= pending_replies.size();
    end

endmodule

// ----- verif/tb_per_client_window_rate_limiter_unit.sv -----
// top of the rate limiter testbench: clock, reset, request and register stimulus, verdict
module tb_per_client_window_rate_limiter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 700;
    localparam int SILENCE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 2 * pcrl_pkg::DEPTH + 16;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    pcrl_pkg::req_t             in_data;
    logic                       out_valid;
    logic                       out_stall;
    pcrl_pkg::rsp_t             out_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [pcrl_pkg::REG_W-1:0] cfg_index;
    logic [pcrl_pkg::CNT_W-1:0] cfg_data;
    int                         mismatches;
    int                         outstanding;

    logic                       gaps_on = 1'b1;
    logic [pcrl_pkg::KEY_W-1:0] client_pool [96];

    per_client_window_rate_limiter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcrl_limit_check limit_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_req(input logic [pcrl_pkg::KEY_W-1:0] key,
                            input logic [pcrl_pkg::TIME_W-1:0] stamp);
        pcrl_pkg::req_t beat;
        int             gap;
        beat.client_key  = key;
        beat.now_seconds = stamp;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= beat;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // holds valid across back-to-back writes, drops it after the last one
    task automatic write_reg(input pcrl_pkg::reg_idx_t idx,
                             input logic [pcrl_pkg::CNT_W-1:0] value,
                             input logic last);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (last)
        begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic load_regs(input logic en, input logic [pcrl_pkg::CNT_W-1:0] reqs,
                             input logic [pcrl_pkg::CNT_W-1:0] burst,
                             input logic [pcrl_pkg::CNT_W-1:0] win);
        write_reg(pcrl_pkg::REG_LIMIT_ENABLED, {15'd0, en}, 1'b0);
        write_reg(pcrl_pkg::REG_REQUESTS, reqs, 1'b0);
        write_reg(pcrl_pkg::REG_BURST, burst, 1'b0);
        write_reg(pcrl_pkg::REG_WINDOW, win, 1'b1);
    endtask

    // stop sending and wait for every reply still owed
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // result side: random stall before each beat
    initial
    begin : reply_sink
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = gaps_on ? $urandom_range(0, 4) : 0;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : watchdog
        int silent;
        silent = 0;
        while (silent < SILENCE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            begin
                silent = 0;
            end
            else
            begin
                silent++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [pcrl_pkg::KEY_W-1:0]  key;
        logic [pcrl_pkg::TIME_W-1:0] clock_s;
        logic                        en;
        logic [pcrl_pkg::CNT_W-1:0]  reqs;
        logic [pcrl_pkg::CNT_W-1:0]  burst;
        logic [pcrl_pkg::CNT_W-1:0]  win;
        int                          pool_size;
        int                          step_max;
        int                          phase_len;
        int                          sent;
        int                          phase;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= pcrl_pkg::REG_LIMIT_ENABLED;
        cfg_data  <= '0;
        foreach (client_pool[i])
        begin
            client_pool[i] = $urandom();
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limiting off after reset: everything passes
        send_req(32'h0000_0000, 32'h0000_0000);
        send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // capacity two, ten second window
        drain();
        load_regs(1'b1, 16'd1, 16'd1, 16'd10);
        send_req(32'hFFFF_FFFF, 32'd100);
        send_req(32'hFFFF_FFFF, 32'd101);
        send_req(32'hFFFF_FFFF, 32'd105);
        send_req(32'h0000_0000, 32'd105);
        send_req(32'hFFFF_FFFF, 32'd110);
        send_req(32'hFFFF_FFFF, 32'd50);
        send_req(32'hFFFF_FFFF, 32'd50);
        send_req(32'hFFFF_FFFF, 32'd59);
        // clock wraps inside one window
        send_req(32'h0000_00A5, 32'hFFFF_FFFE);
        send_req(32'h0000_00A5, 32'd3);
        send_req(32'h0000_00A5, 32'd4);

        // no capacity at all
        drain();
        write_reg(pcrl_pkg::REG_REQUESTS, 16'd0, 1'b0);
        write_reg(pcrl_pkg::REG_BURST, 16'd0, 1'b1);
        send_req(32'h0000_0000, 32'd0);
        drain();
        write_reg(pcrl_pkg::REG_WINDOW, 16'hFFFF, 1'b1);
        send_req(32'h0000_0000, 32'd1);

        // widest capacity with a zero window: refill on every request
        drain();
        load_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
        send_req(32'h0000_0001, 32'd0);
        send_req(32'h0000_0001, 32'd0);

        // capacity lowered while a bucket still holds more tokens
        drain();
        load_regs(1'b1, 16'd3, 16'd0, 16'hFFFF);
        send_req(32'h0000_0007, 32'd1000);
        drain();
        write_reg(pcrl_pkg::REG_REQUESTS, 16'd1, 1'b1);
        send_req(32'h0000_0007, 32'd1001);
        send_req(32'h0000_0007, 32'd1002);
        send_req(32'h0000_0007, 32'd1003);

        sent    = 0;
        phase   = 0;
        clock_s = $urandom();
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            gaps_on = ($urandom_range(0, 3) != 0);
            case (phase % 5)
                0:
                begin
                    // many clients, tiny buckets: table fills and evicts
                    en        = 1'b1;
                    reqs      = 16'($urandom_range(0, 3));
                    burst     = 16'($urandom_range(1, 2));
                    win       = 16'($urandom_range(0, 12));
                    pool_size = $urandom_range(64, 96);
                    step_max  = 2;
                end
                1:
                begin
                    en        = 1'b1;
                    reqs      = 16'($urandom_range(1, 6));
                    burst     = 16'($urandom_range(0, 3));
                    win       = 16'($urandom_range(1, 40));
                    pool_size = $urandom_range(4, 16);
                    step_max  = 3;
                end
                2:
                begin
                    // long windows, denials carry large retry values
                    en        = 1'b1;
                    reqs      = 16'($urandom_range(0, 1));
                    burst     = (reqs == 0) ? 16'd1 : 16'd0;
                    win       = 16'($urandom_range(0, 65535));
                    pool_size = $urandom_range(8, 70);
                    step_max  = 1;
                end
                3:
                begin
                    // either off or enabled with no capacity
                    en        = 1'($urandom_range(0, 1));
                    reqs      = en ? 16'd0 : 16'($urandom_range(0, 65535));
                    burst     = en ? 16'd0 : 16'($urandom_range(0, 65535));
                    win       = 16'($urandom_range(0, 65535));
                    pool_size = 96;
                    step_max  = 5;
                end
                default:
                begin
                    en        = 1'($urandom_range(0, 1));
                    reqs      = 16'($urandom_range(0, 65535));
                    burst     = 16'($urandom_range(0, 65535));
                    win       = 16'($urandom_range(0, 65535));
                    pool_size = $urandom_range(2, 96);
                    step_max  = 1000;
                end
            endcase
            load_regs(en, reqs, burst, win);
            phase_len = $urandom_range(30, 70);
            for (int j = 0; j < phase_len; j++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    key = $urandom();
                end
                else
                begin
                    key = client_pool[$urandom_range(0, pool_size - 1)];
                end
                // occasional jump anywhere, backwards included
                if ($urandom_range(0, 47) == 0)
                begin
                    clock_s = $urandom();
                end
                else
                begin
                    clock_s = clock_s + $urandom_range(0, step_max);
                end
                send_req(key, clock_s);
                sent++;
                if ($urandom_range(0, 59) == 0)
                begin
                    drain();
                end
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pcrl_pkg.sv
hdl/pcrl_cell.sv
hdl/pcrl_ctrl.sv
hdl/per_client_window_rate_limiter_unit.sv
verif/pcrl_limit_check.sv
verif/tb_per_client_window_rate_limiter_unit.sv
